### rtl/bld_pkg.sv
package bld_pkg;

  // Command codes carried on in_tuser
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_CLEAR      = 3'd2;
  localparam logic [2:0] CMD_SEARCH     = 3'd3;
  localparam logic [2:0] CMD_DUMP_FWD   = 3'd4;
  localparam logic [2:0] CMD_DUMP_REV   = 3'd5;

  // Status codes carried on out_tuser
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_ELEMENT   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 4;

  // Sequencer states
  typedef enum logic {
    FSM_IDLE,
    FSM_WALK
  } fsm_state_t;

endpackage

### rtl/bounded_list_deque_with_search_core.sv
// Push, clear, undefined, and search or dump on an empty deque: one result, valid in the
// cycle after the item.
// Search: one stored entry compared per cycle; the result follows a match or the last entry.
// Dumps: count results, one per cycle while out_tready stays high, each read from the store
// and registered to the output; the next item is taken as the last result is taken.
// Reset (rst_n low, synchronous) empties the deque; the store itself is not cleared.
module bounded_list_deque_with_search_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] value
  input  logic [31:0] in_tdata,
  // in_tuser: [2:0] cmd
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [31:0] element, [35:32] position, [39:36] zero fill
  output logic [39:0] out_tdata,
  // out_tuser: [2:0] status
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = bld_pkg::POS_W;

  // Ring slot of a front-relative position: one compare and subtract
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                            input logic [IW-1:0] pos);
    logic [IW:0] s;
    s = {1'b0, front} + {1'b0, pos};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  bld_pkg::fsm_state_t state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          p_v_r, p_v_nxt;
  logic [IW-1:0] p_pos_r, p_pos_nxt;
  logic          p_last_r, p_last_nxt;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [31:0]   out_elem_r;
  logic [IW-1:0] out_pos_r;
  logic          out_last_r;

  logic          out_can, in_fire, out_load;
  logic [2:0]    o_status;
  logic [31:0]   o_elem;
  logic [IW-1:0] o_pos;
  logic          o_last;

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [31:0]   rd_data;

  logic          full, is_search, match, need_out, consume, fin, issue;
  logic [CW-1:0] iss_inc, iss_pos;
  logic [IW-1:0] front_dec;

  assign out_can   = !out_valid_r || out_tready;
  assign in_tready = (state_r == bld_pkg::FSM_IDLE) && out_can;
  assign in_fire   = in_tvalid && in_tready;

  assign full      = (count_r == CW'(DEPTH));
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - IW'(1);

  // Walk pipeline: entry read issued to the registered read port, then compared or sent; a send can stall.
  // Writes happen only in idle and reads only in walk, so no forwarding is needed.
  assign is_search = (mode_r == bld_pkg::CMD_SEARCH);
  assign match     = (rd_data == key_r);
  assign need_out  = is_search ? (match || p_last_r) : 1'b1;
  assign consume   = p_v_r && (!need_out || out_can);
  assign fin       = consume && (is_search ? (match || p_last_r) : p_last_r);
  assign issue     = (!p_v_r || consume) && !fin && (iss_r != count_r);
  assign iss_inc   = iss_r + CW'(1);
  assign iss_pos   = (mode_r == bld_pkg::CMD_DUMP_REV) ? count_r - CW'(1) - iss_r : iss_r;

  bld_ram #(
    .WIDTH (bld_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: next state, store access and result selection
  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    iss_nxt    = iss_r;
    p_v_nxt    = p_v_r;
    p_pos_nxt  = p_pos_r;
    p_last_nxt = p_last_r;
    out_load   = 1'b0;
    o_status   = bld_pkg::ST_DONE;
    o_elem     = '0;
    o_pos      = '0;
    o_last     = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = front_dec;
    rd_en      = 1'b0;
    rd_addr    = slot_of(front_r, iss_pos[IW-1:0]);

    unique case (state_r)
      bld_pkg::FSM_IDLE: begin
        if (in_fire) begin
          unique case (in_tuser) inside
            bld_pkg::CMD_PUSH_FRONT: begin
              out_load = 1'b1;
              if (full) begin
                o_status = bld_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            bld_pkg::CMD_PUSH_BACK: begin
              out_load = 1'b1;
              if (full) begin
                o_status = bld_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = slot_of(front_r, count_r[IW-1:0]);
                count_nxt = count_r + CW'(1);
              end
            end
            bld_pkg::CMD_CLEAR: begin
              out_load  = 1'b1;
              front_nxt = '0;
              count_nxt = '0;
            end
            bld_pkg::CMD_SEARCH, bld_pkg::CMD_DUMP_FWD, bld_pkg::CMD_DUMP_REV: begin
              if (count_r == '0) begin
                out_load = 1'b1;
                o_status = (in_tuser == bld_pkg::CMD_SEARCH) ? bld_pkg::ST_NOT_FOUND
                                                            : bld_pkg::ST_EMPTY;
              end else begin
                state_nxt = bld_pkg::FSM_WALK;
                mode_nxt  = in_tuser;
                key_nxt   = in_tdata;
                iss_nxt   = '0;
                p_v_nxt   = 1'b0;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      bld_pkg::FSM_WALK: begin
        if (consume) begin
          p_v_nxt = 1'b0;
          if (need_out) begin
            out_load = 1'b1;
            if (is_search) begin
              o_status = match ? bld_pkg::ST_FOUND : bld_pkg::ST_NOT_FOUND;
              o_pos    = match ? p_pos_r : '0;
            end else begin
              o_status = bld_pkg::ST_ELEMENT;
              o_elem   = rd_data;
              o_pos    = p_pos_r;
              o_last   = p_last_r;
            end
          end
        end
        if (issue) begin
          rd_en      = 1'b1;
          p_v_nxt    = 1'b1;
          p_pos_nxt  = iss_pos[IW-1:0];
          p_last_nxt = (iss_inc == count_r);
          iss_nxt    = iss_inc;
        end
        if (fin) begin
          state_nxt = bld_pkg::FSM_IDLE;
          p_v_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = bld_pkg::FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bld_pkg::FSM_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      iss_r       <= '0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      iss_r   <= iss_nxt;
      p_v_r   <= p_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    p_pos_r  <= p_pos_nxt;
    p_last_r <= p_last_nxt;
    if (out_load) begin
      out_status_r <= o_status;
      out_elem_r   <= o_elem;
      out_pos_r    <= o_pos;
      out_last_r   <= o_last;
    end
  end

  // Position is reported modulo 16
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, PW'(out_pos_r), out_elem_r};

  // Checks
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> state_r == bld_pkg::FSM_WALK)
    else $error("read pipeline valid outside walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count above depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bld_pkg::FSM_WALK |-> iss_r <= count_r)
    else $error("walk issued past count");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !full &&
    (in_tuser == bld_pkg::CMD_PUSH_FRONT || in_tuser == bld_pkg::CMD_PUSH_BACK)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not grow count");

  a_no_load_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_can)
    else $error("result loaded over a waiting item");

endmodule

### rtl/bld_ram.sv
module bld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
